### hw/rtl/bmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants for the button mode controller.
// ----------------------------------------------------------------------------
package bmc_pkg;

  // Operating modes; code 3 is never produced
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_LOOP   = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_PULSE_MIN  = 2'd0;
  localparam logic [1:0] CFG_PULSE_MAX  = 2'd1;
  localparam logic [1:0] CFG_PULSE_STEP = 2'd2;

  // Configuration reset values
  localparam logic [15:0] PULSE_MIN_RST  = 16'd1000;
  localparam logic [15:0] PULSE_MAX_RST  = 16'd2000;
  localparam logic [9:0]  PULSE_STEP_RST = 10'd10;

  // Lockout counter slots
  localparam logic [1:0] LK_SELECT = 2'd0;
  localparam logic [1:0] LK_UP     = 2'd1;
  localparam logic [1:0] LK_DOWN   = 2'd2;
  localparam logic [1:0] LK_MISC   = 2'd3;

  // Lockout loads in ticks
  localparam logic [5:0] LOCK_SELECT = 6'd20;
  localparam logic [5:0] LOCK_STEP   = 6'd10;
  localparam logic [5:0] LOCK_MISC   = 6'd50;

  // Target force in grams
  localparam logic [8:0] TARGET_START = 9'd50;
  localparam logic [8:0] TARGET_INC   = 9'd10;
  localparam logic [8:0] TARGET_MAX   = 9'd500;

  typedef struct packed {
    logic select;
    logic up;
    logic down;
    logic misc;
  } btn_t;

  typedef struct packed {
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [9:0]  pulse_step;
  } cfg_t;

  typedef struct packed {
    mode_t           mode;
    logic [3:0][5:0] lock;
    logic [8:0]      target;
    logic [15:0]     manual_pulse;
    logic            enable;
  } state_t;

  typedef struct packed {
    logic [15:0] drive_pulse;
    logic        calibrate;
  } step_res_t;

endpackage

### hw/rtl/button_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_mode_controller
// Four-button mode, target and manual pulse controller, one tick per item.
// ----------------------------------------------------------------------------
// Each transaction is one 10 ms tick of button levels and yields one result
// transaction. A tick is captured in an input register, then the update logic
// computes the new state combinationally and loads the result register, so a
// new tick is taken every cycle unless a waiting result stalls it; out_valid
// rises after the input and result registers. The input register keeps
// accepting while a result waits, holding one more tick. Configuration writes
// are meant for idle periods only and do not touch the stored manual pulse.
module button_mode_controller import bmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        select_pressed,
  input  logic        up_pressed,
  input  logic        down_pressed,
  input  logic        misc_pressed,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  mode,
  output logic [15:0] drive_pulse_us,
  output logic [15:0] manual_pulse_us,
  output logic [8:0]  target_grams,
  output logic        loop_enabled,
  output logic        calibrate_request
);

  cfg_t      cfg;
  state_t    state;
  state_t    state_next;
  step_res_t res;
  logic      stage_valid;
  btn_t      stage_btn;
  logic      stage_move;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min  <= PULSE_MIN_RST;
      cfg.pulse_max  <= PULSE_MAX_RST;
      cfg.pulse_step <= PULSE_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PULSE_MIN:  cfg.pulse_min  <= cfg_data;
        CFG_PULSE_MAX:  cfg.pulse_max  <= cfg_data;
        CFG_PULSE_STEP: cfg.pulse_step <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage advances when the result register is free
  assign stage_move = stage_valid && (!out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_move;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_btn <= '{select: select_pressed, up: up_pressed,
                     down: down_pressed, misc: misc_pressed};
    end
  end

  bmc_step u_step (
    .state_cur  (state),
    .cfg        (cfg),
    .btn        (stage_btn),
    .state_next (state_next),
    .res        (res)
  );

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= MODE_IDLE;
      state.lock         <= '0;
      state.target       <= 9'd0;
      state.manual_pulse <= PULSE_MIN_RST;
      state.enable       <= 1'b0;
    end else if (stage_move) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      mode              <= state_next.mode;
      drive_pulse_us    <= res.drive_pulse;
      manual_pulse_us   <= state_next.manual_pulse;
      target_grams      <= state_next.target;
      loop_enabled      <= state_next.enable;
      calibrate_request <= res.calibrate;
    end
  end

  // Checks
  a_cal_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && calibrate_request |-> mode == MODE_IDLE)
    else $error("calibrate request outside idle");

  a_loop_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_LOOP |-> loop_enabled)
    else $error("closed loop without enable flag");

  a_target_max: assert property (@(posedge clk) disable iff (rst)
    state.target <= TARGET_MAX)
    else $error("target above limit");

  a_select_lock: assert property (@(posedge clk) disable iff (rst)
    stage_move && stage_btn.select && state.lock[LK_SELECT] == 6'd0
    |=> state.lock[LK_SELECT] == LOCK_SELECT - 6'd1)
    else $error("select lockout not loaded");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(stage_move) && !$past(rst) |-> $stable(state))
    else $error("state changed without a tick");

endmodule

### hw/rtl/bmc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_step
// Per-tick update: buttons in fixed order, clamps, lockout countdown.
// ----------------------------------------------------------------------------
module bmc_step import bmc_pkg::*; (
  input  state_t    state_cur,
  input  cfg_t      cfg,
  input  btn_t      btn,
  output state_t    state_next,
  output step_res_t res
);

  logic sel_act;
  logic up_act;
  logic down_act;
  logic misc_act;

  assign sel_act  = btn.select && (state_cur.lock[LK_SELECT] == 6'd0);
  assign up_act   = btn.up     && (state_cur.lock[LK_UP]     == 6'd0);
  assign down_act = btn.down   && (state_cur.lock[LK_DOWN]   == 6'd0);
  assign misc_act = btn.misc   && (state_cur.lock[LK_MISC]   == 6'd0);

  // Next state: select, up, down, misc in order
  always_comb begin
    state_t      s;
    logic [16:0] p_up;
    logic [9:0]  t_up;
    logic [15:0] p_dn;
    s = state_cur;

    // select
    if (sel_act) begin
      case (state_cur.mode)
        MODE_IDLE: s.mode = MODE_MANUAL;
        MODE_MANUAL: begin
          s.mode   = MODE_LOOP;
          s.enable = 1'b1;
          s.target = TARGET_START;
        end
        MODE_LOOP: begin
          s.mode   = MODE_IDLE;
          s.enable = 1'b0;
        end
        default: s.mode = MODE_IDLE;
      endcase
    end

    // up
    p_up = {1'b0, s.manual_pulse} + {7'd0, cfg.pulse_step};
    t_up = {1'b0, s.target} + {1'b0, TARGET_INC};
    if (up_act) begin
      if (s.mode == MODE_LOOP) begin
        s.target = (t_up > {1'b0, TARGET_MAX}) ? TARGET_MAX : t_up[8:0];
      end else if (s.mode == MODE_MANUAL) begin
        s.manual_pulse = (p_up > {1'b0, cfg.pulse_max}) ? cfg.pulse_max : p_up[15:0];
      end
    end

    // down
    p_dn = s.manual_pulse - {6'd0, cfg.pulse_step};
    if (down_act) begin
      if (s.mode == MODE_LOOP) begin
        s.target = (s.target < TARGET_INC) ? 9'd0 : s.target - TARGET_INC;
      end else if (s.mode == MODE_MANUAL) begin
        if (s.manual_pulse < {6'd0, cfg.pulse_step}) begin
          s.manual_pulse = cfg.pulse_min;
        end else begin
          s.manual_pulse = (p_dn < cfg.pulse_min) ? cfg.pulse_min : p_dn;
        end
      end
    end

    // misc: recalibrate, back to idle
    if (misc_act) begin
      s.mode = MODE_IDLE;
    end

    // lockouts: a fresh load also counts down this tick
    s.lock[LK_SELECT] = sel_act ? LOCK_SELECT - 6'd1 :
      ((state_cur.lock[LK_SELECT] != 6'd0) ? state_cur.lock[LK_SELECT] - 6'd1 : 6'd0);
    s.lock[LK_UP] = up_act ? LOCK_STEP - 6'd1 :
      ((state_cur.lock[LK_UP] != 6'd0) ? state_cur.lock[LK_UP] - 6'd1 : 6'd0);
    s.lock[LK_DOWN] = down_act ? LOCK_STEP - 6'd1 :
      ((state_cur.lock[LK_DOWN] != 6'd0) ? state_cur.lock[LK_DOWN] - 6'd1 : 6'd0);
    s.lock[LK_MISC] = misc_act ? LOCK_MISC - 6'd1 :
      ((state_cur.lock[LK_MISC] != 6'd0) ? state_cur.lock[LK_MISC] - 6'd1 : 6'd0);

    state_next = s;
  end

  // Outputs derived from the updated state
  always_comb begin
    res.calibrate   = misc_act;
    res.drive_pulse = (state_next.mode == MODE_MANUAL) ? state_next.manual_pulse
                                                       : cfg.pulse_min;
  end

endmodule
